// ----- design/pmc_pkg.sv -----
// Shared types, codes and helper functions of the PID motor controller.
package pmc_pkg;

    // Default values of the top-level parameters.
    localparam int unsigned DEF_ENCODER_COUNTS = 4096;
    localparam int unsigned DEF_PWM_FULL_SCALE = 4096;

    // Control mode codes.
    localparam logic [1:0] MODE_VELOCITY = 2'd0;
    localparam logic [1:0] MODE_POSITION = 2'd1;
    localparam logic [1:0] MODE_TORQUE   = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_MODE            = 3'd0;
    localparam logic [2:0] REG_KP              = 3'd1;
    localparam logic [2:0] REG_INTEGRAL_GAIN   = 3'd2;
    localparam logic [2:0] REG_DERIVATIVE_GAIN = 3'd3;
    localparam logic [2:0] REG_OUT_HI          = 3'd4;
    localparam logic [2:0] REG_OUT_LO          = 3'd5;
    localparam logic [2:0] REG_INT_HI          = 3'd6;
    localparam logic [2:0] REG_INT_LO          = 3'd7;

    // Number of fraction bits of the gains and the accumulated terms.
    localparam int unsigned FRAC_BITS = 16;

    // Signed 48-bit limits of the integral accumulator.
    localparam logic signed [63:0] INT48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] INT48_MIN = -64'sh0000_8000_0000_0000;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] kp;
        logic signed [31:0] integral_gain;
        logic signed [31:0] derivative_gain;
        logic signed [31:0] out_hi;
        logic signed [31:0] out_lo;
        logic signed [31:0] int_hi;
        logic signed [31:0] int_lo;
    } t_cfg;

    // Item after the error stage.
    typedef struct packed {
        logic signed [31:0] err;
        logic signed [32:0] err_delta;
    } t_err_item;

    // Item after the product stage.
    typedef struct packed {
        logic signed [63:0] p_term;
        logic signed [63:0] i_inc;
        logic signed [63:0] d_term;
        logic signed [31:0] err;
    } t_prod_item;

    // Item after the integral stage.
    typedef struct packed {
        logic signed [64:0] p_offset;
        logic signed [47:0] i_term;
        logic signed [63:0] d_term;
        logic signed [31:0] err;
    } t_int_item;

    // Integer limit scaled to Q.16, at the common compare width.
    function automatic logic signed [65:0] q16_limit(input logic signed [31:0] lim);
        q16_limit = 66'(lim) <<< FRAC_BITS;
    endfunction

    // Clamp with the upper limit tested first, so inverted limits resolve to hi.
    function automatic logic signed [65:0] clamp_hi_first(
        input logic signed [65:0] val,
        input logic signed [65:0] hi,
        input logic signed [65:0] lo
    );
        if (val > hi) begin
            clamp_hi_first = hi;
        end else if (val < lo) begin
            clamp_hi_first = lo;
        end else begin
            clamp_hi_first = val;
        end
    endfunction

endpackage

// ----- design/pmc_error_stage.sv -----
// Error stage: forms the mode-dependent loop error and its change since the last sample.
module pmc_error_stage
    import pmc_pkg::*;
#(
    parameter int unsigned ENCODER_COUNTS = DEF_ENCODER_COUNTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_setpoint,
    input  logic signed [31:0] i_measured,
    output logic               o_valid,
    input  logic               i_ready,
    output t_err_item          o_item
);

    localparam logic signed [33:0] HalfCounts = 34'(ENCODER_COUNTS / 2);

    logic               r_valid;
    t_err_item          r_item;
    logic signed [31:0] r_last_err;
    logic signed [32:0] diff;
    logic signed [33:0] raw_err;
    logic signed [31:0] n_err;
    logic               take;

    assign o_ready = !r_valid || i_ready;
    assign take    = o_ready && i_valid;

    // Raw error by mode, one bit wider than the wrap arithmetic needs.
    always_comb begin
        diff    = 33'(i_setpoint) - 33'(i_measured);
        raw_err = '0;
        case (i_cfg.mode)
            MODE_VELOCITY: begin
                raw_err = 34'(diff);
            end
            MODE_POSITION: begin
                if (diff > 0) begin
                    raw_err = HalfCounts - 34'(diff);
                end else if (diff < 0) begin
                    raw_err = -HalfCounts - 34'(diff);
                end else begin
                    raw_err = '0;
                end
            end
            default: begin
                // Torque mode and the unused code force a zero error.
                raw_err = '0;
            end
        endcase
    end

    // Saturate the error to 32 bits.
    always_comb begin
        if (raw_err > 34'sd2147483647) begin
            n_err = 32'sh7FFF_FFFF;
        end else if (raw_err < -34'sd2147483648) begin
            n_err = -32'sh8000_0000;
        end else begin
            n_err = raw_err[31:0];
        end
    end

    // Control state: stage valid and the error of the previous sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_last_err <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (take) begin
                r_last_err <= n_err;
            end
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.err       <= n_err;
            r_item.err_delta <= 33'(n_err) - 33'(r_last_err);
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- design/pmc_product_stage.sv -----
// Product stage: the three gain multiplications, each registered.
module pmc_product_stage
    import pmc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_err_item  i_item,
    output logic       o_valid,
    input  logic       i_ready,
    output t_prod_item o_item
);

    logic               r_valid;
    t_prod_item         r_item;
    logic signed [63:0] n_p_term;
    logic signed [63:0] n_i_inc;
    logic signed [63:0] n_d_term;

    assign o_ready = !r_valid || i_ready;

    // Q16.16 gain times integer error gives Q.16 terms; all fit in 64 bits.
    assign n_p_term = 64'(i_cfg.kp) * 64'(i_item.err);
    assign n_i_inc  = 64'(i_cfg.integral_gain) * 64'(i_item.err);
    assign n_d_term = 64'(i_cfg.derivative_gain) * 64'(i_item.err_delta);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.p_term <= n_p_term;
            r_item.i_inc  <= n_i_inc;
            r_item.d_term <= n_d_term;
            r_item.err    <= i_item.err;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- design/pmc_integral_stage.sv -----
// Integral stage: accumulates the integral with anti-windup clamping.
module pmc_integral_stage
    import pmc_pkg::*;
#(
    parameter int unsigned PWM_FULL_SCALE = DEF_PWM_FULL_SCALE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_prod_item i_item,
    output logic       o_valid,
    input  logic       i_ready,
    output t_int_item  o_item
);

    // Half of the PWM full scale in Q.16.
    localparam logic signed [64:0] PwmOffset = 65'(PWM_FULL_SCALE / 2) <<< FRAC_BITS;

    logic               r_valid;
    t_int_item          r_item;
    logic signed [47:0] r_integral;
    logic signed [63:0] acc_sum;
    logic signed [47:0] acc_sat;
    logic signed [65:0] acc_clamped;
    logic               pos_mode;
    logic               take;

    assign o_ready  = !r_valid || i_ready;
    assign take     = o_ready && i_valid;
    assign pos_mode = (i_cfg.mode == MODE_POSITION);

    // The 48-bit sum plus a 63-bit increment cannot leave 64 bits.
    always_comb begin
        acc_sum = 64'(r_integral) + i_item.i_inc;
        if (acc_sum > INT48_MAX) begin
            acc_sat = INT48_MAX[47:0];
        end else if (acc_sum < INT48_MIN) begin
            acc_sat = INT48_MIN[47:0];
        end else begin
            acc_sat = acc_sum[47:0];
        end
    end

    // Position mode uses its own integral limits, the other modes the output limits.
    always_comb begin
        if (pos_mode) begin
            acc_clamped = clamp_hi_first(66'(acc_sat), q16_limit(i_cfg.int_hi),
                                         q16_limit(i_cfg.int_lo));
        end else begin
            acc_clamped = clamp_hi_first(66'(acc_sat), q16_limit(i_cfg.out_hi),
                                         q16_limit(i_cfg.out_lo));
        end
    end

    // Control state: stage valid and the integral accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_integral <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (take) begin
                r_integral <= acc_clamped[47:0];
            end
        end
    end

    // The total uses the clamped integral in position mode, the unclamped one otherwise.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.p_offset <= 65'(i_item.p_term) + (pos_mode ? PwmOffset : 65'sd0);
            r_item.i_term   <= pos_mode ? acc_clamped[47:0] : acc_sat;
            r_item.d_term   <= i_item.d_term;
            r_item.err      <= i_item.err;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- design/pmc_output_stage.sv -----
// Output stage: sums the terms, clamps to the drive limits and holds the result.
module pmc_output_stage
    import pmc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_int_item          i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_drive,
    output logic signed [31:0] o_loop_error
);

    logic               r_valid;
    logic signed [31:0] r_drive;
    logic signed [31:0] r_loop_error;
    logic signed [65:0] total;
    logic signed [65:0] total_clamped;

    assign o_ready = !r_valid || i_ready;

    // Exact sum; the limits lie well inside 64 bits, so clamping it matches
    // clamping the 64-bit saturated total.
    always_comb begin
        total = 66'(i_item.p_offset) + 66'(i_item.i_term) + 66'(i_item.d_term);
        total_clamped = clamp_hi_first(total, q16_limit(i_cfg.out_hi),
                                       q16_limit(i_cfg.out_lo));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Dropping the fraction bits rounds toward minus infinity.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_drive      <= total_clamped[FRAC_BITS +: 32];
            r_loop_error <= i_item.err;
        end
    end

    assign o_valid      = r_valid;
    assign o_drive      = r_drive;
    assign o_loop_error = r_loop_error;

endmodule

// ----- design/pid_motor_controller.sv -----
// Top level of the PID motor controller: registers, input stage and pipeline.
//
//  Channel       Direction  Transfer when                      Contents
//  s_axis        in         i_s_axis_tvalid & o_s_axis_tready  setpoint, measured
//  m_axis        out        o_m_axis_tvalid & i_m_axis_tready  drive, loop_error
//  cfg           in         i_cfg_we                           register index, value
//
// One sample is taken every cycle unless m_axis stalls; a result passes the input,
// error, product, integral and output registers in that order and can transfer
// from the output register. The integral accumulator closes its loop within
// one stage, which sets the one-cycle rate. Synchronous reset clears the
// registers, the integral and the last error. A stall on m_axis holds each stage
// only once the next one is full.
module pid_motor_controller
    import pmc_pkg::*;
#(
    parameter int unsigned ENCODER_COUNTS = DEF_ENCODER_COUNTS,
    parameter int unsigned PWM_FULL_SCALE = DEF_PWM_FULL_SCALE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] setpoint, [63:32] measured
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata    // [31:0] drive, [63:32] loop_error
);

    t_cfg               r_cfg;
    logic               r_in_valid;
    logic signed [31:0] r_setpoint;
    logic signed [31:0] r_measured;

    logic               err_ready;
    logic               err_valid;
    t_err_item          err_item;
    logic               prod_ready;
    logic               prod_valid;
    t_prod_item         prod_item;
    logic               int_ready;
    logic               int_valid;
    t_int_item          int_item;
    logic               out_ready;
    logic signed [31:0] drive;
    logic signed [31:0] loop_error;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MODE:            r_cfg.mode            <= i_cfg_wdata[1:0];
                REG_KP:              r_cfg.kp              <= i_cfg_wdata;
                REG_INTEGRAL_GAIN:   r_cfg.integral_gain   <= i_cfg_wdata;
                REG_DERIVATIVE_GAIN: r_cfg.derivative_gain <= i_cfg_wdata;
                REG_OUT_HI:          r_cfg.out_hi          <= i_cfg_wdata;
                REG_OUT_LO:          r_cfg.out_lo          <= i_cfg_wdata;
                REG_INT_HI:          r_cfg.int_hi          <= i_cfg_wdata;
                REG_INT_LO:          r_cfg.int_lo          <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    assign o_s_axis_tready = !r_in_valid || err_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_setpoint <= i_s_axis_tdata[31:0];
            r_measured <= i_s_axis_tdata[63:32];
        end
    end

    pmc_error_stage #(
        .ENCODER_COUNTS(ENCODER_COUNTS)
    ) u_error (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (r_in_valid),
        .o_ready    (err_ready),
        .i_setpoint (r_setpoint),
        .i_measured (r_measured),
        .o_valid    (err_valid),
        .i_ready    (prod_ready),
        .o_item     (err_item)
    );

    pmc_product_stage u_product (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (err_valid),
        .o_ready (prod_ready),
        .i_item  (err_item),
        .o_valid (prod_valid),
        .i_ready (int_ready),
        .o_item  (prod_item)
    );

    pmc_integral_stage #(
        .PWM_FULL_SCALE(PWM_FULL_SCALE)
    ) u_integral (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (prod_valid),
        .o_ready (int_ready),
        .i_item  (prod_item),
        .o_valid (int_valid),
        .i_ready (out_ready),
        .o_item  (int_item)
    );

    pmc_output_stage u_output (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (int_valid),
        .o_ready      (out_ready),
        .i_item       (int_item),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_drive      (drive),
        .o_loop_error (loop_error)
    );

    assign o_m_axis_tdata = {loop_error, drive};

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the PID motor controller: stream traffic, register writes, live predictor.
`timescale 1ns / 1ps

module tb_top;
    import pmc_pkg::*;

    localparam int unsigned ENC_COUNTS = DEF_ENCODER_COUNTS;
    localparam int unsigned PWM_SCALE  = DEF_PWM_FULL_SCALE;

    // The spare mode code has no name in the package; it behaves as torque mode.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [1:0] MODE_LIST [4] = '{MODE_VELOCITY, MODE_POSITION, MODE_TORQUE,
                                              MODE_SPARE};

    localparam longint HALF_COUNTS = longint'(ENC_COUNTS / 2);
    localparam longint HALF_PWM    = longint'(PWM_SCALE / 2);
    localparam longint Q_ONE       = 64'sd65536;
    localparam longint I32_MAX     = 64'sd2147483647;
    localparam longint I32_MIN     = -64'sd2147483648;
    localparam longint I64_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN     = 64'sh8000_0000_0000_0000;

    localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_UNITY = 32'h0001_0000;

    // Expected drive and error of one sample, laid out as on the result tdata.
    typedef struct packed {
        logic signed [31:0] loop_error;
        logic signed [31:0] drive;
    } t_drive_result;

    // Clock, reset and driven inputs, all known from time zero.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic [63:0] s_tdata = '0;
    logic        m_tready = 1'b0;

    logic        s_tready;
    logic        m_tvalid;
    logic [63:0] m_tdata;

    // Bench-side copy of the registers and the loop state.
    logic [1:0] cfg_mode = MODE_VELOCITY;
    longint cfg_kp = 0, cfg_igain = 0, cfg_dgain = 0;
    longint cfg_max_out = 0, cfg_min_out = 0, cfg_max_int = 0, cfg_min_int = 0;
    longint integ_acc = 0;
    longint last_err = 0;

    t_drive_result drive_expect_q [$];
    t_drive_result exp_res, got_res;
    int mismatch_count = 0;
    int src_idle_pct = 9;
    int snk_idle_pct = 64;
    int hold_left = 0;

    pid_motor_controller #(
        .ENCODER_COUNTS(ENC_COUNTS),
        .PWM_FULL_SCALE(PWM_SCALE)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [31:0] setpoint, [63:32] measured
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)    // [31:0] drive, [63:32] loop_error
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop in case the stream stalls for good.
    initial begin
        #2_000_000;
        $display("pid_motor_controller verification failed");
        $finish;
    end

    // Upper bound is tested first, so inverted bounds resolve to hi.
    function automatic longint bound(longint v, longint hi, longint lo);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // 64-bit addition that saturates instead of wrapping.
    function automatic longint sat_add(longint a, longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? I64_MIN : I64_MAX;
        return s[63:0];
    endfunction

    // One control step: error by mode, integral with anti-windup, clamped drive.
    function automatic t_drive_result pid_step(logic signed [31:0] setpoint,
                                               logic signed [31:0] measured);
        longint diff, err, p_term, d_term, total;
        logic pos;
        t_drive_result res;
        diff = longint'(setpoint) - longint'(measured);
        pos = (cfg_mode == MODE_POSITION);
        err = 0;
        if (cfg_mode == MODE_VELOCITY) begin
            err = diff;
        end else if (pos) begin
            // Position wraps around half a turn of the encoder.
            if (diff > 0) err = HALF_COUNTS - diff;
            else if (diff < 0) err = -(HALF_COUNTS + diff);
        end
        err = bound(err, I32_MAX, I32_MIN);

        p_term = cfg_kp * err;
        d_term = cfg_dgain * (err - last_err);
        integ_acc = bound(sat_add(integ_acc, cfg_igain * err), INT48_MAX, INT48_MIN);

        if (!pos) begin
            // Output uses the raw integral; the integral is clamped afterwards.
            total = sat_add(sat_add(p_term, integ_acc), d_term);
            integ_acc = bound(integ_acc, cfg_max_out * Q_ONE, cfg_min_out * Q_ONE);
        end else begin
            integ_acc = bound(integ_acc, cfg_max_int * Q_ONE, cfg_min_int * Q_ONE);
            total = sat_add(HALF_PWM * Q_ONE, p_term);
            total = sat_add(sat_add(total, integ_acc), d_term);
        end

        // Clamp in Q.16, then drop the fraction (rounds toward minus infinity).
        total = bound(total, cfg_max_out * Q_ONE, cfg_min_out * Q_ONE);
        total = bound(total >>> 16, I32_MAX, I32_MIN);
        last_err = err;
        res.drive = total[31:0];
        res.loop_error = err[31:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what,
                 $signed(got), $signed(want));
        mismatch_count++;
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Check each result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            got_res = m_tdata;
            if (drive_expect_q.size() == 0) begin
                report_mismatch("result with nothing pending", got_res.drive, '0);
            end else begin
                exp_res = drive_expect_q.pop_front();
                if (got_res.drive !== exp_res.drive)
                    report_mismatch("drive", got_res.drive, exp_res.drive);
                if (got_res.loop_error !== exp_res.loop_error)
                    report_mismatch("loop_error", got_res.loop_error, exp_res.loop_error);
            end
        end
    end

    // Offer one sample, with random idle cycles first; predict on transfer.
    task automatic send_sample(logic [31:0] setpoint, logic [31:0] measured);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {measured, setpoint};
        do @(posedge i_clk); while (!s_tready);
        drive_expect_q.push_back(pid_step(setpoint, measured));
    endtask

    // Stop offering and wait until every pending result has been taken.
    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (drive_expect_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE:            cfg_mode = value[1:0];
            REG_KP:              cfg_kp = longint'($signed(value));
            REG_INTEGRAL_GAIN:   cfg_igain = longint'($signed(value));
            REG_DERIVATIVE_GAIN: cfg_dgain = longint'($signed(value));
            REG_OUT_HI:          cfg_max_out = longint'($signed(value));
            REG_OUT_LO:          cfg_min_out = longint'($signed(value));
            REG_INT_HI:          cfg_max_int = longint'($signed(value));
            REG_INT_LO:          cfg_min_int = longint'($signed(value));
            default: begin
            end
        endcase
    endtask

    // Rewrite every register once the pipeline is empty.
    task automatic set_config(logic [1:0] mode, logic [31:0] kp, logic [31:0] igain,
                              logic [31:0] dgain, logic [31:0] max_out,
                              logic [31:0] min_out, logic [31:0] max_int,
                              logic [31:0] min_int);
        drain();
        write_reg(REG_MODE, 32'(mode));
        write_reg(REG_KP, kp);
        write_reg(REG_INTEGRAL_GAIN, igain);
        write_reg(REG_DERIVATIVE_GAIN, dgain);
        write_reg(REG_OUT_HI, max_out);
        write_reg(REG_OUT_LO, min_out);
        write_reg(REG_INT_HI, max_int);
        write_reg(REG_INT_LO, min_int);
    endtask

    // Gain mix: full range, small fixed-point values, and the extremes.
    function automatic logic [31:0] rand_gain();
        case ($urandom_range(3))
            0: return $urandom;
            1: return ($urandom_range(1) ? W_MAX : W_MIN);
            default: return 32'($urandom_range(0, 32'h0006_0000)) - 32'h0003_0000;
        endcase
    endfunction

    // Samples: full range, close pairs, and pairs around the position wrap.
    task automatic send_random_samples(int count);
        logic [31:0] sp, ms;
        repeat (count) begin
            case ($urandom_range(3))
                0: begin
                    sp = $urandom;
                    ms = $urandom;
                end
                1: begin
                    sp = 32'($urandom_range(0, 20000)) - 32'd10000;
                    ms = sp + 32'($urandom_range(0, 600)) - 32'd300;
                end
                default: begin
                    ms = $urandom;
                    sp = ms + 32'($urandom_range(0, 2 * ENC_COUNTS)) - 32'(ENC_COUNTS);
                end
            endcase
            send_sample(sp, ms);
        end
    endtask

    // Registers at reset: zero gains and limits, so the drive stays at zero.
    task automatic test_reset_state();
        send_sample(W_MIN, W_MAX);
        send_sample(W_MAX, W_MIN);
        send_sample(32'd0, 32'd0);
    endtask

    // Each mode, the position wrap in both directions, and floor rounding.
    task automatic test_error_modes();
        set_config(MODE_VELOCITY, Q_UNITY, 32'h0000_8000, 32'h0000_4000,
                   32'd1000, -32'sd1000, 32'd0, 32'd0);
        send_sample(32'd100, 32'd40);
        send_sample(-32'sd300, 32'd200);
        send_sample(32'd5000, 32'd0);
        // Half gain on an odd negative error leaves a fraction to round down.
        set_config(MODE_VELOCITY, 32'h0000_8000, 32'd0, 32'd0,
                   32'd1000, -32'sd1000, 32'd0, 32'd0);
        send_sample(32'd0, 32'd3);
        set_config(MODE_POSITION, Q_UNITY, 32'h0000_0100, 32'd0,
                   32'(PWM_SCALE), 32'd0, 32'd100, -32'sd100);
        send_sample(32'd10, 32'd10);
        send_sample(32'd3000, 32'd100);
        send_sample(32'd100, 32'd3000);
        send_sample(W_MAX, W_MIN);
        send_sample(W_MIN, W_MAX);
        set_config(MODE_TORQUE, Q_UNITY, Q_UNITY, Q_UNITY, 32'd500, -32'sd500,
                   32'd0, 32'd0);
        send_sample(32'd1234, -32'sd5678);
        drain();
        write_reg(REG_MODE, 32'(MODE_SPARE));
        send_sample(W_MAX, 32'd0);
    endtask

    // Inverted limits, then gains at the extremes so every sum saturates.
    task automatic test_limits_and_overflow();
        set_config(MODE_VELOCITY, Q_UNITY, 32'd0, 32'd0, -32'sd50, 32'd50,
                   32'd0, 32'd0);
        send_sample(32'd10, 32'd0);
        send_sample(-32'sd100, 32'd0);
        set_config(MODE_VELOCITY, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN);
        send_sample(W_MAX, W_MIN);
        send_sample(W_MIN, W_MAX);
        send_sample(W_MIN, W_MAX);
        send_sample(W_MAX, W_MIN);
        set_config(MODE_POSITION, W_MAX, W_MAX, W_MAX, W_MAX, W_MIN, W_MAX, W_MIN);
        send_sample(W_MIN, 32'd1);
        send_sample(32'd1, W_MIN);
    endtask

    // Random register settings under one idling pattern.
    task automatic test_random_regime(int src_pct, int snk_pct);
        logic [31:0] lo, hi, tmp;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (5) begin
            case ($urandom_range(3))
                0: begin
                    hi = W_MAX;
                    lo = W_MIN;
                end
                1: begin
                    hi = $urandom;
                    lo = $urandom;
                end
                default: begin
                    hi = 32'($urandom_range(1, 100000));
                    lo = -32'($urandom_range(0, 100000));
                end
            endcase
            // Now and then swap the bounds so min sits above max.
            if ($urandom_range(5) == 0) begin
                tmp = hi;
                hi = lo;
                lo = tmp;
            end
            set_config(MODE_LIST[$urandom_range(3)], rand_gain(), rand_gain(), rand_gain(),
                       hi, lo, 32'($urandom_range(0, 200000)),
                       -32'($urandom_range(0, 200000)));
            send_random_samples(56);
        end
    endtask

    // Receiver holds off while samples keep coming, then the sender pauses.
    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 20;
        set_config(MODE_VELOCITY, Q_UNITY, 32'h0000_0800, 32'h0000_2000,
                   32'd200000, -32'sd200000, 32'd0, 32'd0);
        hold_left = 300;
        send_random_samples(40);
        drain();
        send_random_samples(20);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_error_modes();
        test_limits_and_overflow();
        test_random_regime(9, 64);
        test_random_regime(64, 9);
        test_random_regime(0, 0);
        test_backpressure();
        drain();

        if (mismatch_count == 0 && drive_expect_q.size() == 0) begin
            $display("pid_motor_controller verification clean");
        end else begin
            $display("pid_motor_controller verification failed");
        end
        $finish;
    end

endmodule
